// ----- hw/rtl/fully_connected_layer_forward_macros.svh -----
// Assertion shorthands for the fully connected layer checker.
`ifndef FULLY_CONNECTED_LAYER_FORWARD_MACROS_SVH
`define FULLY_CONNECTED_LAYER_FORWARD_MACROS_SVH

// Checked outside reset only.
`define FCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FCL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fcl_pkg.sv -----
package fcl_pkg;

	localparam int IN_MAX  = 1024;
	localparam int OUT_MAX = 64;

	localparam int WDEPTH  = IN_MAX * OUT_MAX;
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int CNT_W   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
	localparam int OIDX_W  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

	localparam int CFG_IN_W   = 11;
	localparam int CFG_OUT_W  = 7;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	localparam int ROW_W  = 10;
	localparam int MROW_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;
	localparam int PROD_W = MROW_W + 8;
	localparam int CMP_W  = (CNT_W + 1 > CFG_IN_W) ? CNT_W + 1 : CFG_IN_W;

	localparam int ACC_W  = 42;
	localparam int SUM_W  = ACC_W + 1;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_ACT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IN_UNITS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_UNITS = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [ROW_W-1:0]   row;
		logic [5:0]         col;
		logic signed [15:0] value;
	} fcl_in_t;

	typedef struct packed {
		logic [5:0]         out_index;
		logic signed [31:0] out_value;
		logic               last;
	} fcl_out_t;

	// Clamped register values as the datapath uses them.
	typedef struct packed {
		logic [CFG_IN_W-1:0]  n_in;
		logic [CFG_OUT_W-1:0] n_out;
	} fcl_cfg_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic [1:0]         op;
		logic [WADDR_W-1:0] addr;
		logic [5:0]         col;
		logic signed [15:0] value;
		logic               last;
	} fcl_cmd_t;

endpackage

// ----- hw/rtl/fcl_front.sv -----
module fcl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  fcl_pkg::fcl_cfg_t cfg,
	input  logic             item_valid,
	output logic             item_stall,
	input  fcl_pkg::fcl_in_t item,
	input  logic             q_full,
	output logic             push,
	output fcl_pkg::fcl_cmd_t push_cmd
);
	import fcl_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic [MROW_W-1:0] mrow;
	logic [PROD_W-1:0] addr_full;
	logic [CMP_W-1:0]  cnt_next;
	logic              is_last;
	logic              accept;
	logic              is_act;
	logic              keep;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign is_act     = (item.opcode == OP_ACT);

	// Activations address the row given by the running input count.
	assign mrow      = is_act ? MROW_W'(cnt_q) : MROW_W'(item.row);
	assign addr_full = PROD_W'(mrow) * PROD_W'(cfg.n_out)
		+ (is_act ? '0 : PROD_W'(item.col));

	assign cnt_next = CMP_W'(cnt_q) + CMP_W'(1);
	assign is_last  = (cnt_next >= CMP_W'(cfg.n_in));

	always_comb begin
		case (item.opcode)
			OP_WEIGHT: keep = 1'b1;
			OP_BIAS:   keep = (7'(item.col) < 7'(OUT_MAX));
			OP_ACT:    keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	assign push           = accept && keep;
	assign push_cmd.op    = item.opcode;
	assign push_cmd.addr  = addr_full[WADDR_W-1:0];
	assign push_cmd.col   = item.col;
	assign push_cmd.value = item.value;
	assign push_cmd.last  = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && is_act) begin
			cnt_q <= is_last ? '0 : cnt_next[CNT_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/fcl_queue.sv -----
module fcl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fcl_pkg::fcl_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output fcl_pkg::fcl_cmd_t head
);
	import fcl_pkg::*;

	fcl_cmd_t            fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/fcl_back.sv -----
module fcl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fcl_pkg::fcl_cfg_t cfg,
	input  logic              cmd_valid,
	input  fcl_pkg::fcl_cmd_t cmd,
	output logic              cmd_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output fcl_pkg::fcl_out_t result
);
	import fcl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_MAC     = 5'b00010,
		S_DRAIN   = 5'b00100,
		S_EMIT_RD = 5'b01000,
		S_EMIT_WR = 5'b10000
	} fcl_state_t;

	fcl_state_t state_q;

	logic [15:0]      w_mem   [WDEPTH];
	logic [ACC_W-1:0] acc_mem [OUT_MAX];
	logic [15:0]      b_mem   [OUT_MAX];
	logic [OUT_MAX-1:0] acc_vld_q;

	logic [OIDX_W-1:0]  o_q;
	logic [WADDR_W-1:0] base_q;
	logic signed [15:0] act_q;
	logic               last_q;
	logic               o_last;

	// Read stage: memory data registered.
	logic               v_s1;
	logic [OIDX_W-1:0]  idx_s1;
	logic signed [15:0] w_s1;
	logic [ACC_W-1:0]   acc_s1;
	logic               accv_s1;
	logic signed [15:0] bias_s1;

	// Multiply stage.
	logic               v_s2;
	logic [OIDX_W-1:0]  idx_s2;
	logic signed [31:0] prod_s2;
	logic [ACC_W-1:0]   acc_s2;

	logic [ACC_W-1:0]   acc_new;
	logic [ACC_W-1:0]   acc_cur;
	logic [SUM_W-1:0]   sum;
	logic               fits;
	logic [31:0]        sat;
	logic               load_out;
	logic               result_valid_q;
	fcl_out_t           result_q;

	assign cmd_pop = cmd_valid && (state_q == S_IDLE);
	assign o_last  = (CFG_OUT_W'(o_q) == (cfg.n_out - CFG_OUT_W'(1)));

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_WEIGHT) begin
			w_mem[cmd.addr] <= cmd.value;
		end
		w_s1 <= w_mem[base_q + WADDR_W'(o_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_BIAS) begin
			b_mem[cmd.col[OIDX_W-1:0]] <= cmd.value;
		end
		bias_s1 <= b_mem[o_q];
	end

	assign acc_new = acc_s2 + {{(ACC_W - 32){prod_s2[31]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_mem[idx_s2] <= acc_new;
		end
		acc_s1 <= acc_mem[o_q];
	end

	always_ff @(posedge clk) begin
		accv_s1 <= acc_vld_q[o_q];
		idx_s1  <= o_q;
		idx_s2  <= idx_s1;
		prod_s2 <= act_q * w_s1;
		acc_s2  <= acc_cur;
		if (cmd_pop && cmd.op == OP_ACT) begin
			act_q  <= cmd.value;
			base_q <= cmd.addr;
			last_q <= cmd.last;
		end
	end

	// An accumulator that has not been written since the last sample reads as zero.
	assign acc_cur = accv_s1 ? acc_s1 : '0;

	assign sum = {acc_cur[ACC_W-1], acc_cur}
		+ {{(SUM_W - 24){bias_s1[15]}}, bias_s1, 8'h00};
	assign fits = (&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31]);

	always_comb begin
		if (fits) begin
			sat = sum[31:0];
		end else if (sum[SUM_W-1]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7FFF_FFFF;
		end
	end

	assign load_out = (state_q == S_EMIT_WR) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.out_index <= 6'(o_q);
			result_q.out_value <= sat;
			result_q.last      <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			o_q            <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			acc_vld_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_MAC);
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_vld_q[idx_s2] <= 1'b1;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_pop && cmd.op == OP_ACT) begin
						o_q     <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (o_last) begin
						state_q <= S_DRAIN;
					end else begin
						o_q <= o_q + OIDX_W'(1);
					end
				end
				S_DRAIN: begin
					// Wait until the last accumulator write has landed.
					if (!v_s1 && !v_s2) begin
						o_q     <= '0;
						state_q <= last_q ? S_EMIT_RD : S_IDLE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (load_out) begin
						if (o_last) begin
							acc_vld_q <= '0;
							state_q   <= S_IDLE;
						end else begin
							o_q     <= o_q + OIDX_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- hw/rtl/fully_connected_layer_forward.sv -----
// Weight and bias loads are written to memory as the back end pops them; the four-entry queue hides them.
// An activation steps through out_units_used outputs in the single multiply-accumulate unit.
// The final activation of a sample then emits out_units_used results, each read, then loaded into the output register.
// An accepted item passes through the queue before the back end sees it; results leave through a register.
// Reset sets in_units_used to 1024, out_units_used to 64, and clears the input count
// and all accumulators; weights and biases are undefined until loaded.
module fully_connected_layer_forward (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  fcl_pkg::fcl_in_t                    item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output fcl_pkg::fcl_out_t                   result,
	input  logic                                cfg_we,
	input  logic [fcl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fcl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fcl_pkg::*;

	logic [CFG_IN_W-1:0]  in_units_q;
	logic [CFG_OUT_W-1:0] out_units_q;
	fcl_cfg_t             cfg;

	logic     push;
	fcl_cmd_t push_cmd;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	fcl_cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_units_q  <= CFG_IN_W'(1024);
			out_units_q <= CFG_OUT_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_UNITS:  in_units_q  <= cfg_data[CFG_IN_W-1:0];
				REG_OUT_UNITS: out_units_q <= cfg_data[CFG_OUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero acts as one and values above the maximum act as the maximum.
	always_comb begin
		if (in_units_q == '0) begin
			cfg.n_in = CFG_IN_W'(1);
		end else if (int'(in_units_q) > IN_MAX) begin
			cfg.n_in = CFG_IN_W'(IN_MAX);
		end else begin
			cfg.n_in = in_units_q;
		end
		if (out_units_q == '0) begin
			cfg.n_out = CFG_OUT_W'(1);
		end else if (int'(out_units_q) > OUT_MAX) begin
			cfg.n_out = CFG_OUT_W'(OUT_MAX);
		end else begin
			cfg.n_out = out_units_q;
		end
	end

	fcl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	fcl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fcl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_valid    (head_valid),
		.cmd          (head),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- hw/rtl/fcl_checker.sv -----
`include "fully_connected_layer_forward_macros.svh"

module fcl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           result_valid,
	input logic                           result_stall,
	input fcl_pkg::fcl_out_t              result
);
	import fcl_pkg::*;

	logic [5:0] expect_idx_q;

	// Results of a sample count up from zero and restart after the one marked last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_idx_q <= '0;
		end else if (result_valid && !result_stall) begin
			expect_idx_q <= result.last ? 6'd0 : expect_idx_q + 6'd1;
		end
	end

	`FCL_ASSERT(a_valid_holds, result_valid && result_stall |=> result_valid, "result dropped while stalled")
	`FCL_ASSERT(a_payload_holds, result_valid && result_stall |=> $stable(result), "stalled result changed")
	`FCL_ASSERT(a_index_order, result_valid |-> result.out_index == expect_idx_q, "result index out of order")
	`FCL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !result_valid, "result valid during reset")

endmodule

bind fully_connected_layer_forward fcl_checker u_fcl_checker (.*);
